// ----- hdl/lirs_pkg.sv -----
// ----------------------------------------------------------------------------
// lirs_pkg
// Shared types and constants of the linear interpolation resampler.
// ----------------------------------------------------------------------------
`default_nettype none

package lirs_pkg;

	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	localparam logic [2:0] REG_STEP_RATIO   = 3'd0;
	localparam logic [2:0] REG_FRAME_COUNT  = 3'd1;
	localparam logic [2:0] REG_SOURCE_MONO  = 3'd2;
	localparam logic [2:0] REG_SOURCE_8BIT  = 3'd3;
	localparam logic [2:0] REG_OUT_COUNT    = 3'd4;

	localparam logic [23:0] STEP_RATIO_RESET  = 24'h01_0000;
	localparam logic [14:0] FRAME_COUNT_RESET = 15'd1;
	localparam logic [16:0] OUT_COUNT_RESET   = 17'd1;

	localparam int SAMPLE_W     = 16;
	localparam int FRAC_W       = 16;
	localparam int OUT_CHANNELS = 2;

	localparam logic KIND_LOAD    = 1'b0;
	localparam logic KIND_REQUEST = 1'b1;

	typedef struct packed {
		logic [23:0] step_ratio;
		logic [14:0] source_frame_count;
		logic        source_mono;
		logic        source_8bit;
		logic [16:0] output_frame_count;
	} cfg_t;

endpackage

`default_nettype wire

// ----- hdl/lirs_regs.sv -----
// ----------------------------------------------------------------------------
// lirs_regs
// Configuration registers of the resampler behind an APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module lirs_regs
	import lirs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[PADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_ratio         <= STEP_RATIO_RESET;
			cfg_q.source_frame_count <= FRAME_COUNT_RESET;
			cfg_q.source_mono        <= 1'b0;
			cfg_q.source_8bit        <= 1'b0;
			cfg_q.output_frame_count <= OUT_COUNT_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_STEP_RATIO:  cfg_q.step_ratio         <= pwdata[23:0];
				REG_FRAME_COUNT: cfg_q.source_frame_count <= pwdata[14:0];
				REG_SOURCE_MONO: cfg_q.source_mono        <= pwdata[0];
				REG_SOURCE_8BIT: cfg_q.source_8bit        <= pwdata[0];
				REG_OUT_COUNT:   cfg_q.output_frame_count <= pwdata[16:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_STEP_RATIO:  prdata = PDATA_W'(cfg_q.step_ratio);
			REG_FRAME_COUNT: prdata = PDATA_W'(cfg_q.source_frame_count);
			REG_SOURCE_MONO: prdata = PDATA_W'(cfg_q.source_mono);
			REG_SOURCE_8BIT: prdata = PDATA_W'(cfg_q.source_8bit);
			REG_OUT_COUNT:   prdata = PDATA_W'(cfg_q.output_frame_count);
			default:         prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ----- hdl/linear_interp_resampler_unit.sv -----
// ----------------------------------------------------------------------------
// linear_interp_resampler_unit
// Linear interpolation resampler producing stereo 16-bit frames.
//
// The command channel (cmd_valid, cmd_stall) carries two kinds of item. A load
// item writes one raw source frame into the sample memory at frame_index. A
// request item asks for output frame frame_index and yields one item on the
// response channel (rsp_valid, rsp_stall) with both interpolated channels and
// the last-frame flag. Registers are to be set over the APB port while the block is
// idle; the block itself does not enforce it.
// A request reads two source frames in turn through the single port of the
// sample memory, so the issue stage frees only after both reads; a load needs
// one write. The result then passes stages 3 and 4 to the response register.
// When the receiver stalls, the response register holds its item and the back
// end of the pipeline freezes; commands are still taken until the two front
// stages are full. Reset empties the pipeline and restores the registers; the
// sample memory is not cleared, and frames must be loaded before they are read.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_interp_resampler_unit
	import lirs_pkg::*;
#(
	parameter int unsigned SOURCE_DEPTH      = 16384,
	parameter int unsigned MAX_OUTPUT_FRAMES = 65536
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [PADDR_W-1:0]         paddr,
	input  logic [PDATA_W-1:0]         pwdata,
	output logic [PDATA_W-1:0]         prdata,
	output logic                       pready,
	input  logic                       cmd_valid,
	output logic                       cmd_stall,
	input  logic                       kind,
	input  logic [15:0]                frame_index,
	input  logic [15:0]                sample_left,
	input  logic [15:0]                sample_right,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output logic signed [SAMPLE_W-1:0] out_left,
	output logic signed [SAMPLE_W-1:0] out_right,
	output logic                       last_frame
);

	localparam int unsigned AW  = $clog2(SOURCE_DEPTH);
	localparam int unsigned CW  = ((AW > 15) ? AW : 15) + 1;
	localparam int unsigned LW  = ((AW > 16) ? AW : 16) + 1;
	localparam int unsigned OW  = ($clog2(MAX_OUTPUT_FRAMES + 1) > 17) ?
		$clog2(MAX_OUTPUT_FRAMES + 1) : 17;
	localparam logic [CW-1:0] DEPTH_C    = CW'(SOURCE_DEPTH);
	localparam logic [CW-1:0] DEPTH_M1_C = CW'(SOURCE_DEPTH - 1);
	localparam logic [LW-1:0] DEPTH_L    = LW'(SOURCE_DEPTH);
	localparam logic [OW-1:0] MAX_OUT_C  = OW'(MAX_OUTPUT_FRAMES);
	localparam logic [32:0] RND_POS = 33'd32768;
	localparam logic [32:0] RND_NEG = 33'd32767;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

	function automatic logic signed [SAMPLE_W-1:0] widen(input logic [SAMPLE_W-1:0] raw,
		input logic is_8bit);
		if (is_8bit) begin
			return {~raw[7], raw[6:0], 8'h00};
		end
		return raw;
	endfunction

	cfg_t cfg;

	lirs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Last usable source frame, derived from the frame count.
	logic [CW-1:0] count_w;
	logic [AW-1:0] last_idx_q;

	assign count_w = CW'(cfg.source_frame_count);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_idx_q <= '0;
		end else if (count_w == '0) begin
			last_idx_q <= '0;
		end else if (count_w > DEPTH_C) begin
			last_idx_q <= DEPTH_M1_C[AW-1:0];
		end else begin
			last_idx_q <= AW'(count_w - 1'b1);
		end
	end

	// Stage 1: accepted item, source position.
	logic        accept;
	logic        v_s1;
	logic        kind_s1;
	logic        last_s1;
	logic [15:0] fidx_s1;
	logic [31:0] data_s1;
	logic [39:0] pos_s1;
	logic [39:0] pos_c;
	logic        last_c;
	logic        out_cnt_ok;

	logic s2_free;

	assign cmd_stall  = v_s1 && !s2_free;
	assign accept     = cmd_valid && !cmd_stall;
	assign pos_c      = frame_index * cfg.step_ratio;
	assign out_cnt_ok = (cfg.output_frame_count != '0) &&
		(OW'(cfg.output_frame_count) <= MAX_OUT_C);
	assign last_c     = out_cnt_ok &&
		({1'b0, frame_index} == (cfg.output_frame_count - 17'd1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept || (v_s1 && !s2_free);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= kind;
			fidx_s1 <= frame_index;
			data_s1 <= {sample_right, sample_left};
			pos_s1  <= pos_c;
			last_s1 <= last_c;
		end
	end

	// Stage 2: memory issue. A request takes two reads, a load one write.
	logic [23:0]       pos_hi;
	logic [AW-1:0]     idx0_c;
	logic [AW-1:0]     idx1_c;
	logic              mv12;
	logic              v_s2;
	logic              ph_s2;
	logic              kind_s2;
	logic              inr_s2;
	logic              last_s2;
	logic [AW-1:0]     idx0_s2;
	logic [AW-1:0]     idx1_s2;
	logic [FRAC_W-1:0] frac_s2;
	logic [31:0]       data_s2;
	logic              s2_done;
	logic              rd0;
	logic              rd1;
	logic              mem_we;
	logic              mem_re;
	logic [AW-1:0]     mem_addr;
	logic              bk_en;

	assign pos_hi = pos_s1[39:16];
	assign idx0_c = (pos_hi > 24'(last_idx_q)) ? last_idx_q : pos_hi[AW-1:0];
	assign idx1_c = (idx0_c != last_idx_q) ? AW'(idx0_c + 1'b1) : idx0_c;

	assign mv12    = v_s1 && s2_free;
	assign rd0     = v_s2 && (kind_s2 == KIND_REQUEST) && !ph_s2 && bk_en;
	assign rd1     = v_s2 && (kind_s2 == KIND_REQUEST) && ph_s2 && bk_en;
	assign s2_done = v_s2 && ((kind_s2 == KIND_LOAD) || rd1);
	assign s2_free = !v_s2 || s2_done;

	assign mem_we   = v_s2 && (kind_s2 == KIND_LOAD) && inr_s2;
	assign mem_re   = rd0 || rd1;
	assign mem_addr = ph_s2 ? idx1_s2 : idx0_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2  <= 1'b0;
			ph_s2 <= 1'b0;
		end else begin
			v_s2 <= mv12 || (v_s2 && !s2_done);
			if (mv12 || s2_done) begin
				ph_s2 <= 1'b0;
			end else if (rd0) begin
				ph_s2 <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mv12) begin
			kind_s2 <= kind_s1;
			inr_s2  <= LW'(fidx_s1) < DEPTH_L;
			idx0_s2 <= (kind_s1 == KIND_LOAD) ? AW'(fidx_s1) : idx0_c;
			idx1_s2 <= idx1_c;
			frac_s2 <= pos_s1[FRAC_W-1:0];
			last_s2 <= last_s1;
			data_s2 <= data_s1;
		end
	end

	// Sample memory: raw left bits low, raw right bits high.
	logic [31:0] sample_mem_q [SOURCE_DEPTH];
	logic [31:0] rdata_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			sample_mem_q[mem_addr] <= data_s2;
		end
		if (mem_re) begin
			rdata_q <= sample_mem_q[mem_addr];
		end
	end

	// Stage 3: first frame held, second frame on the memory output.
	logic              v_s3;
	logic [31:0]       w0_s3;
	logic [FRAC_W-1:0] frac_s3;
	logic              last_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (bk_en) begin
			v_s3 <= rd1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd1) begin
			w0_s3   <= rdata_q;
			frac_s3 <= frac_s2;
			last_s3 <= last_s2;
		end
	end

	logic signed [SAMPLE_W-1:0] s0_c   [OUT_CHANNELS];
	logic signed [SAMPLE_W-1:0] s1_c   [OUT_CHANNELS];
	logic signed [SAMPLE_W:0]   diff_c [OUT_CHANNELS];
	logic signed [33:0]         prod_c [OUT_CHANNELS];

	always_comb begin
		for (int ch = 0; ch < OUT_CHANNELS; ch++) begin
			if ((ch != 0) && !cfg.source_mono) begin
				s0_c[ch] = widen(w0_s3[2*SAMPLE_W-1:SAMPLE_W], cfg.source_8bit);
				s1_c[ch] = widen(rdata_q[2*SAMPLE_W-1:SAMPLE_W], cfg.source_8bit);
			end else begin
				s0_c[ch] = widen(w0_s3[SAMPLE_W-1:0], cfg.source_8bit);
				s1_c[ch] = widen(rdata_q[SAMPLE_W-1:0], cfg.source_8bit);
			end
			diff_c[ch] = {s1_c[ch][SAMPLE_W-1], s1_c[ch]} - {s0_c[ch][SAMPLE_W-1], s0_c[ch]};
			prod_c[ch] = diff_c[ch] * $signed({1'b0, frac_s3});
		end
	end

	// Stage 4: interpolation products.
	logic                       v_s4;
	logic                       last_s4;
	logic signed [SAMPLE_W-1:0] s0_s4   [OUT_CHANNELS];
	logic signed [32:0]         prod_s4 [OUT_CHANNELS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (bk_en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (bk_en && v_s3) begin
			last_s4 <= last_s3;
			for (int ch = 0; ch < OUT_CHANNELS; ch++) begin
				s0_s4[ch]   <= s0_c[ch];
				prod_s4[ch] <= prod_c[ch][32:0];
			end
		end
	end

	// Rounding half away from zero and saturation.
	logic signed [32:0]         acc_c [OUT_CHANNELS];
	logic signed [32:0]         rnd_c [OUT_CHANNELS];
	logic signed [16:0]         r_c   [OUT_CHANNELS];
	logic signed [SAMPLE_W-1:0] res_c [OUT_CHANNELS];

	always_comb begin
		for (int ch = 0; ch < OUT_CHANNELS; ch++) begin
			acc_c[ch] = {s0_s4[ch][SAMPLE_W-1], s0_s4[ch], 16'h0000} + prod_s4[ch];
			rnd_c[ch] = acc_c[ch] + (acc_c[ch][32] ? RND_NEG : RND_POS);
			r_c[ch]   = rnd_c[ch][32:16];
			if (r_c[ch][16] == r_c[ch][15]) begin
				res_c[ch] = r_c[ch][15:0];
			end else if (r_c[ch][16]) begin
				res_c[ch] = SAMPLE_MIN;
			end else begin
				res_c[ch] = SAMPLE_MAX;
			end
		end
	end

	// Response register.
	logic                       rsp_valid_q;
	logic                       last_q;
	logic signed [SAMPLE_W-1:0] res_q [OUT_CHANNELS];

	assign bk_en = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (bk_en) begin
			rsp_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (bk_en && v_s4) begin
			last_q <= last_s4;
			for (int ch = 0; ch < OUT_CHANNELS; ch++) begin
				res_q[ch] <= res_c[ch];
			end
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign out_left   = res_q[0];
	assign out_right  = res_q[1];
	assign last_frame = last_q;

`ifndef NO_ASSERTIONS
	a_port_single_op: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("Sample memory read and written in the same cycle.");

	a_phase_on_request: assert property (@(posedge clk) disable iff (!arst_n)
		ph_s2 |-> (v_s2 && (kind_s2 == KIND_REQUEST)))
		else $error("Second read phase without a request in the issue stage.");

	a_neighbor_frames: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && (kind_s2 == KIND_REQUEST)) |->
		((idx1_s2 == idx0_s2) || (idx1_s2 == AW'(idx0_s2 + 1'b1))))
		else $error("Interpolation frames are not neighbors.");

	a_back_end_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=> ($stable(v_s3) && $stable(v_s4) && !$past(mem_re)))
		else $error("Back end moved while the response was stalled.");
`endif

endmodule

`default_nettype wire
